// ===== design/rtts_pkg.sv =====
package rtts_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = IDX_W + 1;

    localparam logic [7:0]  START_DATA   = 8'hAF;
    localparam logic [31:0] KEEPALIVE_MS = 32'd100;

    localparam logic [1:0] MODE_SIMPLE = 2'd0;
    localparam logic [1:0] MODE_TURN   = 2'd1;
    localparam logic [1:0] MODE_SYNC   = 2'd2;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_ENQUEUE = 3'd1;
    localparam logic [2:0] OP_SERVICE = 3'd2;
    localparam logic [2:0] OP_TXDONE  = 3'd3;
    localparam logic [2:0] OP_RECEIVE = 3'd4;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_TOOLARGE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [1:0] SENT_NONE = 2'd0;
    localparam logic [1:0] SENT_DATA = 2'd1;
    localparam logic [1:0] SENT_SYNC = 2'd2;

    localparam logic [2:0] REG_SCHED_MODE  = 3'd0;
    localparam logic [2:0] REG_TURN_TMO    = 3'd1;
    localparam logic [2:0] REG_GUARD       = 3'd2;
    localparam logic [2:0] REG_CONN_TMO    = 3'd3;
    localparam logic [2:0] REG_BEACON      = 3'd4;
    localparam logic [2:0] REG_MAX_PACKET  = 3'd5;
    localparam logic [2:0] REG_SEND_BUDGET = 3'd6;

    typedef enum logic [5:0] {
        K_NOP     = 6'b000001,
        K_TICK    = 6'b000010,
        K_ENQUEUE = 6'b000100,
        K_SERVICE = 6'b001000,
        K_TXDONE  = 6'b010000,
        K_RECEIVE = 6'b100000
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [8:0] pkt_bytes;
        logic       is_data_start;
        logic       radio_ready;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  sched_mode;
        logic [15:0] turn_timeout_ms;
        logic [15:0] guard_time_ms;
        logic [15:0] connection_timeout_ms;
        logic [15:0] beacon_interval_ms;
        logic [8:0]  max_packet_bytes;
        logic [12:0] send_budget_bytes;
    } t_cfg;

    typedef struct packed {
        logic [15:0] tx_error_count;
        logic        link_connected;
        logic        overflow_flag;
        logic [12:0] bytes_queued;
        logic        forward_received;
        logic [8:0]  sent_length;
        logic [1:0]  sent_kind;
        logic [1:0]  status;
    } t_result;

endpackage

// ===== design/radio_tx_turn_scheduler.sv =====
// Transmit-turn scheduler for a half-duplex packet radio. Each input item (tick, enqueue,
// service, tx done, receive) gives exactly one result item. Items pass through a two-entry
// command queue into a back end that computes all next scheduler state combinationally and
// registers it, so one item per clock is sustained while m_axis_tready stays high. An accepted
// item is held in the command queue register; the back end then registers its result, and
// m_axis_tvalid rises with that result register. The packet length queue is a 32-entry memory
// with a registered read of its head entry. Registers sit at byte addresses 4*i on the APB port
// and should be written only while the block is idle.
module radio_tx_turn_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] pkt_bytes, [16:9] lead_byte, [17] radio_ready, [23:18] zero
    input  logic [23:0] s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [3:2] sent_kind, [12:4] sent_length, [13] forward_received,
    // [26:14] bytes_queued, [27] overflow_flag, [28] link_connected,
    // [44:29] tx_error_count, [47:45] zero
    output logic [47:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rtts_pkg::t_cfg    r_cfg;
    rtts_pkg::t_cmd    w_cmd;
    rtts_pkg::t_result w_res;
    logic              w_cmd_valid;
    logic              w_cmd_ready;
    logic              w_wr;
    logic [2:0]        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sched_mode            <= rtts_pkg::MODE_SIMPLE;
            r_cfg.turn_timeout_ms       <= 16'd1000;
            r_cfg.guard_time_ms         <= 16'd50;
            r_cfg.connection_timeout_ms <= 16'd2000;
            r_cfg.beacon_interval_ms    <= 16'd1000;
            r_cfg.max_packet_bytes      <= 9'd256;
            r_cfg.send_budget_bytes     <= 13'd2048;
        end else if (w_wr) begin
            case (w_idx)
                rtts_pkg::REG_SCHED_MODE:  r_cfg.sched_mode            <= pwdata[1:0];
                rtts_pkg::REG_TURN_TMO:    r_cfg.turn_timeout_ms       <= pwdata[15:0];
                rtts_pkg::REG_GUARD:       r_cfg.guard_time_ms         <= pwdata[15:0];
                rtts_pkg::REG_CONN_TMO:    r_cfg.connection_timeout_ms <= pwdata[15:0];
                rtts_pkg::REG_BEACON:      r_cfg.beacon_interval_ms    <= pwdata[15:0];
                rtts_pkg::REG_MAX_PACKET:  r_cfg.max_packet_bytes      <= pwdata[8:0];
                rtts_pkg::REG_SEND_BUDGET: r_cfg.send_budget_bytes     <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rtts_pkg::REG_SCHED_MODE:  prdata = {30'd0, r_cfg.sched_mode};
            rtts_pkg::REG_TURN_TMO:    prdata = {16'd0, r_cfg.turn_timeout_ms};
            rtts_pkg::REG_GUARD:       prdata = {16'd0, r_cfg.guard_time_ms};
            rtts_pkg::REG_CONN_TMO:    prdata = {16'd0, r_cfg.connection_timeout_ms};
            rtts_pkg::REG_BEACON:      prdata = {16'd0, r_cfg.beacon_interval_ms};
            rtts_pkg::REG_MAX_PACKET:  prdata = {23'd0, r_cfg.max_packet_bytes};
            rtts_pkg::REG_SEND_BUDGET: prdata = {19'd0, r_cfg.send_budget_bytes};
            default:                   prdata = 32'd0;
        endcase
    end

    rtts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_operation   (s_axis_tuser),
        .i_pkt_bytes   (s_axis_tdata[8:0]),
        .i_lead_byte   (s_axis_tdata[16:9]),
        .i_radio_ready (s_axis_tdata[17]),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    rtts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {3'd0, w_res};

endmodule

// ===== design/rtts_front.sv =====
module rtts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_operation,
    input  logic [8:0]    i_pkt_bytes,
    input  logic [7:0]    i_lead_byte,
    input  logic          i_radio_ready,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output rtts_pkg::t_cmd o_cmd
);

    rtts_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    rtts_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.pkt_bytes     = i_pkt_bytes;
        w_cmd.is_data_start = (i_lead_byte == rtts_pkg::START_DATA);
        w_cmd.radio_ready   = i_radio_ready;
        case (i_operation)
            rtts_pkg::OP_TICK:    w_cmd.kind = rtts_pkg::K_TICK;
            rtts_pkg::OP_ENQUEUE: w_cmd.kind = rtts_pkg::K_ENQUEUE;
            rtts_pkg::OP_SERVICE: w_cmd.kind = rtts_pkg::K_SERVICE;
            rtts_pkg::OP_TXDONE:  w_cmd.kind = rtts_pkg::K_TXDONE;
            rtts_pkg::OP_RECEIVE: w_cmd.kind = rtts_pkg::K_RECEIVE;
            default:              w_cmd.kind = rtts_pkg::K_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/rtts_back.sv =====
module rtts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtts_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  rtts_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output rtts_pkg::t_result o_res
);

    logic [8:0]                   r_mem [rtts_pkg::QUEUE_DEPTH];
    logic [8:0]                   r_rd;
    logic [rtts_pkg::IDX_W-1:0]   r_head, n_head;
    logic [rtts_pkg::CNT_W-1:0]   r_count, n_count;
    logic [12:0]                  r_queued, n_queued;
    logic                         r_tx_free, n_tx_free;
    logic                         r_heard, n_heard;
    logic [31:0]                  r_ms_send, n_ms_send;
    logic [31:0]                  r_ms_recv, n_ms_recv;
    logic                         r_connected, n_connected;
    logic                         r_turn_rx, n_turn_rx;
    logic                         r_overflow, n_overflow;
    logic [15:0]                  r_rejects, n_rejects;
    logic                         r_out_valid;
    rtts_pkg::t_result            r_out, n_out;

    logic                         w_fire;
    logic                         w_wr_en;
    logic [rtts_pkg::IDX_W-1:0]   w_wr_addr;
    logic [rtts_pkg::SUM_W-1:0]   w_sum;
    logic [8:0]                   w_head_len;
    logic                         w_svc;
    logic                         w_do_data;
    logic                         w_do_sync;
    logic [31:0]                  w_gap;
    logic [13:0]                  w_need;

    assign o_cmd_ready = !r_out_valid || i_res_ready;
    assign w_fire      = i_cmd_valid && o_cmd_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        w_sum = rtts_pkg::SUM_W'(r_head) + rtts_pkg::SUM_W'(r_count);
        if (w_sum >= rtts_pkg::SUM_W'(rtts_pkg::QUEUE_DEPTH)) begin
            w_sum = w_sum - rtts_pkg::SUM_W'(rtts_pkg::QUEUE_DEPTH);
        end
        w_wr_addr = w_sum[rtts_pkg::IDX_W-1:0];
        w_need    = {5'd0, i_cmd.pkt_bytes} + {1'b0, r_queued};
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_queued    = r_queued;
        n_tx_free   = r_tx_free;
        n_heard     = r_heard;
        n_ms_send   = r_ms_send;
        n_ms_recv   = r_ms_recv;
        n_connected = r_connected;
        n_turn_rx   = r_turn_rx;
        n_overflow  = r_overflow;
        n_rejects   = r_rejects;
        n_out       = '0;
        w_wr_en     = 1'b0;
        w_svc       = 1'b0;
        w_do_data   = 1'b0;
        w_do_sync   = 1'b0;
        w_gap       = 32'd0;
        w_head_len  = r_rd;

        if (w_fire) begin
            case (i_cmd.kind)
                rtts_pkg::K_TICK: begin
                    if (r_ms_send != 32'hFFFF_FFFF) begin
                        n_ms_send = r_ms_send + 32'd1;
                    end
                    if (r_ms_recv != 32'hFFFF_FFFF) begin
                        n_ms_recv = r_ms_recv + 32'd1;
                    end
                end
                rtts_pkg::K_ENQUEUE: begin
                    if (i_cmd.pkt_bytes > i_cfg.max_packet_bytes) begin
                        n_out.status = rtts_pkg::ST_TOOLARGE;
                        if (r_rejects != 16'hFFFF) begin
                            n_rejects = r_rejects + 16'd1;
                        end
                    end else if (w_need > {1'b0, i_cfg.send_budget_bytes} ||
                                 r_count >= rtts_pkg::CNT_W'(rtts_pkg::QUEUE_DEPTH)) begin
                        n_out.status = rtts_pkg::ST_OVERFLOW;
                        n_overflow   = 1'b1;
                        if (r_rejects != 16'hFFFF) begin
                            n_rejects = r_rejects + 16'd1;
                        end
                    end else begin
                        w_wr_en      = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_queued     = w_need[12:0];
                        n_overflow   = 1'b0;
                        n_out.status = rtts_pkg::ST_ACCEPTED;
                        w_svc        = 1'b1;
                        if (r_count == '0) begin
                            w_head_len = i_cmd.pkt_bytes;
                        end
                    end
                end
                rtts_pkg::K_SERVICE: begin
                    w_svc = 1'b1;
                end
                rtts_pkg::K_TXDONE: begin
                    n_tx_free = 1'b1;
                end
                rtts_pkg::K_RECEIVE: begin
                    n_heard   = 1'b1;
                    n_ms_recv = 32'd0;
                    if (i_cfg.sched_mode == rtts_pkg::MODE_SYNC) begin
                        n_turn_rx              = 1'b0;
                        n_connected            = 1'b1;
                        n_out.forward_received = i_cmd.is_data_start;
                    end else begin
                        n_out.forward_received = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_svc && n_tx_free) begin
            case (i_cfg.sched_mode)
                rtts_pkg::MODE_SIMPLE: begin
                    w_do_data = (n_count != '0);
                end
                rtts_pkg::MODE_TURN: begin
                    w_do_data = (n_count != '0) &&
                                (n_heard || r_ms_send > {16'd0, i_cfg.turn_timeout_ms});
                end
                rtts_pkg::MODE_SYNC: begin
                    if (!(n_turn_rx && r_ms_recv < {16'd0, i_cfg.guard_time_ms})) begin
                        if (r_ms_recv > {16'd0, i_cfg.connection_timeout_ms}) begin
                            n_connected = 1'b0;
                        end
                        w_gap = n_connected ? rtts_pkg::KEEPALIVE_MS
                                            : {16'd0, i_cfg.beacon_interval_ms};
                        if (n_count != '0) begin
                            w_do_data = 1'b1;
                        end else begin
                            w_do_sync = (r_ms_send > w_gap);
                        end
                        n_turn_rx = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (i_cmd.radio_ready && (w_do_data || w_do_sync)) begin
                n_tx_free = 1'b0;
                n_ms_send = 32'd0;
                n_heard   = 1'b0;
                if (w_do_data) begin
                    n_head = (r_head == rtts_pkg::IDX_W'(rtts_pkg::QUEUE_DEPTH - 1)) ?
                             '0 : r_head + 1'b1;
                    n_count = n_count - 1'b1;
                    n_queued = ({4'd0, w_head_len} <= n_queued) ?
                               n_queued - {4'd0, w_head_len} : 13'd0;
                    n_out.sent_kind   = rtts_pkg::SENT_DATA;
                    n_out.sent_length = w_head_len;
                end else begin
                    n_out.sent_kind = rtts_pkg::SENT_SYNC;
                end
            end
        end

        n_out.bytes_queued   = n_queued;
        n_out.overflow_flag  = n_overflow;
        n_out.link_connected = n_connected;
        n_out.tx_error_count = n_rejects;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_cmd.pkt_bytes;
        end
        if (w_wr_en && (w_wr_addr == n_head)) begin
            r_rd <= i_cmd.pkt_bytes;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_queued    <= 13'd0;
            r_tx_free   <= 1'b1;
            r_heard     <= 1'b1;
            r_ms_send   <= 32'd0;
            r_ms_recv   <= 32'd0;
            r_connected <= 1'b0;
            r_turn_rx   <= 1'b0;
            r_overflow  <= 1'b0;
            r_rejects   <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_queued    <= n_queued;
            r_tx_free   <= n_tx_free;
            r_heard     <= n_heard;
            r_ms_send   <= n_ms_send;
            r_ms_recv   <= n_ms_recv;
            r_connected <= n_connected;
            r_turn_rx   <= n_turn_rx;
            r_overflow  <= n_overflow;
            r_rejects   <= n_rejects;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
